### src/acsw_pkg.sv
`default_nettype none

package acsw_pkg;

    localparam int TIME_BITS_DEF  = 48;
    localparam int COUNT_BITS_DEF = 32;

    // Fixed field widths on the stream ports.
    localparam int CMD_BITS    = 3;
    localparam int NOW_BITS    = 48;
    localparam int VALUE_BITS  = 48;
    localparam int STATUS_BITS = 2;
    localparam int IN_BYTES_W  = 56;
    localparam int OUT_BYTES_W = 56;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_START   = 3'd0,
        CMD_STOP    = 3'd1,
        CMD_ELAPSED = 3'd2,
        CMD_LAST    = 3'd3,
        CMD_AVERAGE = 3'd4,
        CMD_CLEAR   = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_STATE = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        MODE_EMPTY   = 2'd0,
        MODE_RUNNING = 2'd1,
        MODE_STOPPED = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_ADD  = 2'd1,
        S_DIV  = 2'd2,
        S_FIN  = 2'd3
    } t_state;

endpackage

`default_nettype wire

### src/accumulating_stopwatch.sv
// A stop or elapsed item while running, or an average with at least one sample, passes
// through the bit-serial add/subtract pass or the one-bit-per-cycle restoring divider before
// S_FIN; every other item goes straight to S_FIN. S_FIN registers the result once the output
// is free. A new item is accepted only in S_IDLE, so one item is handled at a time.
// Reset: synchronous, active low; clears the stopwatch state and the output valid flag.
`default_nettype none

module accumulating_stopwatch #(
    parameter int TIME_BITS  = acsw_pkg::TIME_BITS_DEF,
    parameter int COUNT_BITS = acsw_pkg::COUNT_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // [2:0] cmd, [50:3] now, [55:51] zero
    input  wire logic [acsw_pkg::IN_BYTES_W-1:0]  i_s_tdata,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // [47:0] value, [49:48] status, [55:50] zero
    output logic      [acsw_pkg::OUT_BYTES_W-1:0] o_m_tdata
);

    import acsw_pkg::*;

    localparam int CNT_W = $clog2(TIME_BITS);

    t_state                r_state, n_state;
    t_mode                 r_mode;
    t_cmd                  r_cmd;
    logic [TIME_BITS-1:0]  r_start, r_total, r_last;
    logic [COUNT_BITS-1:0] r_count;

    // Serial work registers.
    logic [TIME_BITS-1:0]  r_a, r_b, r_c, r_span, r_sum, r_quo;
    logic [COUNT_BITS-1:0] r_rem;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_borrow, r_carry;

    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_value;
    t_status               r_status;

    t_cmd                  in_cmd;
    logic [TIME_BITS-1:0]  in_now;
    logic                  accept, out_free, last_bit;
    logic                  span_bit, n_borrow, sum_bit, n_carry;
    logic [COUNT_BITS:0]   rem_sh;
    logic [COUNT_BITS+1:0] rem_diff;
    logic                  rem_ge;
    logic                  count_zero, count_full;

    assign in_cmd     = t_cmd'(i_s_tdata[CMD_BITS-1:0]);
    assign in_now     = TIME_BITS'(i_s_tdata[CMD_BITS +: NOW_BITS]);
    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign last_bit   = (r_cnt == CNT_W'(TIME_BITS - 1));
    assign count_zero = (r_count == '0);
    assign count_full = (r_count == '1);

    // One bit of now - start and of total + span per cycle, LSB first.
    assign span_bit = r_a[0] ^ r_b[0] ^ r_borrow;
    assign n_borrow = (~r_a[0] & r_b[0]) | (~(r_a[0] ^ r_b[0]) & r_borrow);
    assign sum_bit  = span_bit ^ r_c[0] ^ r_carry;
    assign n_carry  = (span_bit & r_c[0]) | (span_bit & r_carry) | (r_c[0] & r_carry);

    // Restoring division step: shift one dividend bit into the remainder.
    assign rem_sh   = {r_rem, r_quo[TIME_BITS-1]};
    assign rem_diff = {1'b0, rem_sh} - {2'b00, r_count};
    assign rem_ge   = ~rem_diff[COUNT_BITS+1];

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_BYTES_W - VALUE_BITS - STATUS_BITS){1'b0}}, r_status, r_value};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if ((in_cmd == CMD_STOP || in_cmd == CMD_ELAPSED)
                        && r_mode == MODE_RUNNING) begin
                        n_state = S_ADD;
                    end else if (in_cmd == CMD_AVERAGE && !count_zero) begin
                        n_state = S_DIV;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_ADD, S_DIV: begin
                if (last_bit) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Work registers carry payload only and need no reset.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_cmd    <= in_cmd;
                    r_a      <= in_now;
                    r_b      <= r_start;
                    r_c      <= r_total;
                    r_quo    <= r_total;
                    r_rem    <= '0;
                    r_cnt    <= '0;
                    r_borrow <= 1'b0;
                    r_carry  <= 1'b0;
                end
            end
            S_ADD: begin
                r_a      <= r_a >> 1;
                r_b      <= r_b >> 1;
                r_c      <= r_c >> 1;
                r_span   <= {span_bit, r_span[TIME_BITS-1:1]};
                r_sum    <= {sum_bit, r_sum[TIME_BITS-1:1]};
                r_borrow <= n_borrow;
                r_carry  <= n_carry;
                r_cnt    <= r_cnt + 1'b1;
            end
            S_DIV: begin
                r_quo <= {r_quo[TIME_BITS-2:0], rem_ge};
                r_rem <= rem_ge ? rem_diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
                r_cnt <= r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_EMPTY;
            r_start     <= '0;
            r_total     <= '0;
            r_last      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
                r_value     <= '0;
                r_status    <= ST_OK;
                case (r_cmd)
                    CMD_START: begin
                        if (r_mode == MODE_RUNNING) begin
                            r_status <= ST_STATE;
                        end else begin
                            r_start <= r_a;
                            r_mode  <= MODE_RUNNING;
                        end
                    end
                    CMD_STOP: begin
                        if (r_mode != MODE_RUNNING) begin
                            r_status <= ST_STATE;
                        end else if (r_borrow || r_carry || count_full) begin
                            r_status <= ST_RANGE;
                        end else begin
                            r_last  <= r_span;
                            r_total <= r_sum;
                            r_count <= r_count + 1'b1;
                            r_mode  <= MODE_STOPPED;
                            r_value <= VALUE_BITS'(r_span);
                        end
                    end
                    CMD_ELAPSED: begin
                        if (r_mode != MODE_RUNNING) begin
                            r_value <= VALUE_BITS'(r_total);
                        end else if (r_borrow || r_carry) begin
                            // Saturate to the largest time value.
                            r_value <= VALUE_BITS'({TIME_BITS{1'b1}});
                        end else begin
                            r_value <= VALUE_BITS'(r_sum);
                        end
                    end
                    CMD_LAST: begin
                        if (count_zero) begin
                            r_status <= ST_STATE;
                        end else begin
                            r_value <= VALUE_BITS'(r_last);
                        end
                    end
                    CMD_AVERAGE: begin
                        if (count_zero) begin
                            r_status <= ST_STATE;
                        end else begin
                            r_value <= VALUE_BITS'(r_quo);
                        end
                    end
                    CMD_CLEAR: begin
                        r_mode  <= MODE_EMPTY;
                        r_start <= '0;
                        r_total <= '0;
                        r_last  <= '0;
                        r_count <= '0;
                    end
                    default: r_status <= ST_STATE;
                endcase
            end
        end
    end

endmodule

`default_nettype wire
